@@ rtl/pse_pkg.sv @@
// Shared types and constants for the prefix-sharing string encoder.
// Holds the input, queue and result word layouts. No dependencies.
`timescale 1ns / 1ps

package pse_pkg;

	localparam int MAX_STRING = 1024;
	localparam int POS_W = 16;
	localparam int CNT_W = 16;
	localparam logic [POS_W-1:0] POS_MAX = '1;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;
	localparam int MID_DEPTH = 4;
	localparam int OUT_DEPTH = 2;

	localparam logic KIND_SUFFIX = 1'b0;
	localparam logic KIND_LENGTH = 1'b1;

	typedef struct packed {
		logic [7:0] str_byte;
		logic       byte_valid;
		logic       end_of_string;
		logic       first_of_page;
	} pse_in_t;

	typedef struct packed {
		logic             record_kind;
		logic [7:0]       suffix_byte;
		logic [CNT_W-1:0] prefix_length;
		logic [CNT_W-1:0] suffix_length;
		logic             length_overflow;
		logic             last_of_run;
	} pse_out_t;

	typedef struct packed {
		logic [7:0] data;
		logic       has_byte;
		logic       is_match;
		logic       closes;
	} pse_mid_t;

endpackage

@@ rtl/pse_fifo.sv @@
// Small synchronous first-in first-out queue of register entries.
// Used between the front and back parts and as the result buffer. Uses pse_pkg for nothing.
`timescale 1ns / 1ps

module pse_fifo #(
	parameter int Width = 8,
	parameter int Depth = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  logic [Width-1:0] wdata,
	output logic             full,
	input  logic             rd,
	output logic [Width-1:0] rdata,
	output logic             empty
);

	localparam int PW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CW = $clog2(Depth + 1);

	logic [Width-1:0] mem_q [Depth];
	logic [PW-1:0]    wp_q;
	logic [PW-1:0]    rp_q;
	logic [CW-1:0]    cnt_q;
	logic             wr_ok;
	logic             rd_ok;

	assign full  = (cnt_q == CW'(Depth));
	assign empty = (cnt_q == '0);
	assign wr_ok = wr && !full;
	assign rd_ok = rd && !empty;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr_ok) begin
			mem_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_ok) begin
				wp_q <= (wp_q == PW'(Depth - 1)) ? '0 : wp_q + 1'b1;
			end
			if (rd_ok) begin
				rp_q <= (rp_q == PW'(Depth - 1)) ? '0 : rp_q + 1'b1;
			end
			if (wr_ok && !rd_ok) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd_ok && !wr_ok) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(Depth))
		else $error("fifo count beyond depth");

	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0 || cnt_q == CW'(Depth)) |-> (wp_q == rp_q))
		else $error("fifo pointers disagree with count");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		wr |-> !full)
		else $error("write into full fifo");

endmodule

@@ rtl/pse_front.sv @@
// Front part: accepts words, tracks position, reads and rewrites the string buffer,
// and classifies each byte as prefix match or suffix byte. Depends on pse_pkg.
`timescale 1ns / 1ps

module pse_front #(
	parameter int MaxString = pse_pkg::MAX_STRING
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  pse_pkg::pse_in_t  item,
	output logic              full,
	output logic              mid_wr,
	output pse_pkg::pse_mid_t mid_word,
	input  logic              mid_full
);

	import pse_pkg::*;

	localparam int AW = (MaxString > 1) ? $clog2(MaxString) : 1;
	localparam int LW = $clog2(MaxString + 1);

	logic [7:0]       mem_q [MaxString];
	logic [7:0]       rd_q;
	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] pos_n;
	logic [LW-1:0]    plen_q;
	logic             has_prev_q;
	logic             match_q;
	logic             accept;
	logic             in_range;
	logic             cmp_ok;

	logic       s1_valid_q;
	logic [7:0] byte_s1;
	logic       has_byte_s1;
	logic       closes_s1;
	logic       kill_s1;
	logic       cmp_ok_s1;

	logic s1_move;
	logic sm;
	logic is_match;

	assign s1_move = s1_valid_q && !mid_full;
	assign full    = s1_valid_q && mid_full;
	assign accept  = push && !full;

	assign in_range = (pos_q != POS_MAX) && (32'(pos_q) < MaxString);
	assign cmp_ok   = in_range && (32'(pos_q) < 32'(plen_q));
	assign pos_n    = (item.byte_valid && pos_q != POS_MAX) ? pos_q + 1'b1 : pos_q;

	always_ff @(posedge clk) begin
		if (accept && item.byte_valid && cmp_ok) begin
			rd_q <= mem_q[pos_q[AW-1:0]];
		end
		if (accept && item.byte_valid && in_range) begin
			mem_q[pos_q[AW-1:0]] <= item.str_byte;
		end
		if (accept) begin
			byte_s1     <= item.str_byte;
			has_byte_s1 <= item.byte_valid;
			closes_s1   <= item.end_of_string;
			kill_s1     <= item.first_of_page || !has_prev_q;
			cmp_ok_s1   <= cmp_ok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			plen_q     <= '0;
			has_prev_q <= 1'b0;
			s1_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
				if (item.end_of_string) begin
					pos_q      <= '0;
					plen_q     <= (32'(pos_n) < MaxString) ? LW'(pos_n) : LW'(MaxString);
					has_prev_q <= 1'b1;
				end else begin
					pos_q <= pos_n;
				end
			end else if (s1_move) begin
				s1_valid_q <= 1'b0;
			end
		end
	end

	assign sm       = match_q && !kill_s1;
	assign is_match = has_byte_s1 && sm && cmp_ok_s1 && (rd_q == byte_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b1;
		end else if (s1_move) begin
			if (closes_s1) begin
				match_q <= 1'b1;
			end else if (has_byte_s1 && !is_match) begin
				match_q <= 1'b0;
			end else begin
				match_q <= sm;
			end
		end
	end

	assign mid_wr            = s1_move;
	assign mid_word.data     = byte_s1;
	assign mid_word.has_byte = has_byte_s1;
	assign mid_word.is_match = is_match;
	assign mid_word.closes   = closes_s1;

	a_s1_no_clobber: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s1_valid_q) |-> s1_move)
		else $error("front stage overwritten before moving on");

	a_match_in_buffer: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_move && is_match) |-> (cmp_ok_s1 && has_byte_s1 && !kill_s1))
		else $error("match reported outside stored string");

	a_pos_reset: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && item.end_of_string) |=> (pos_q == '0 && has_prev_q))
		else $error("position not cleared at end of string");

endmodule

@@ rtl/pse_back.sv @@
// Back part: keeps prefix and suffix counts and turns classified words into
// suffix byte and length record results. Depends on pse_pkg.
`timescale 1ns / 1ps

module pse_back (
	input  logic              clk,
	input  logic              arst_n,
	input  pse_pkg::pse_mid_t entry,
	input  logic              mid_empty,
	output logic              mid_rd,
	output logic              out_wr,
	output pse_pkg::pse_out_t out_word,
	input  logic              out_full
);

	import pse_pkg::*;

	typedef enum logic {
		PH_BYTE,
		PH_RECORD
	} phase_t;

	phase_t           ph_q;
	logic [CNT_W-1:0] pc_q;
	logic [CNT_W-1:0] sc_q;
	logic             ov_q;
	logic [CNT_W-1:0] pc_n;
	logic [CNT_W-1:0] sc_n;
	logic             ov_n;
	logic             go;
	logic             eff_byte;
	logic             emit_byte;
	logic             emit_rec;

	assign go        = !mid_empty && !out_full;
	assign eff_byte  = (ph_q == PH_BYTE) && entry.has_byte;
	assign emit_byte = eff_byte && !entry.is_match;
	assign emit_rec  = entry.closes && !emit_byte;

	always_comb begin
		pc_n = pc_q;
		sc_n = sc_q;
		ov_n = ov_q;
		if (eff_byte && entry.is_match) begin
			if (pc_q == CNT_MAX) begin
				ov_n = 1'b1;
			end else begin
				pc_n = pc_q + 1'b1;
			end
		end
		if (emit_byte) begin
			if (sc_q == CNT_MAX) begin
				ov_n = 1'b1;
			end else begin
				sc_n = sc_q + 1'b1;
			end
		end
	end

	always_comb begin
		out_word = '0;
		if (emit_byte) begin
			out_word.record_kind = KIND_SUFFIX;
			out_word.suffix_byte = entry.data;
			out_word.last_of_run = !entry.closes;
		end else begin
			out_word.record_kind     = KIND_LENGTH;
			out_word.prefix_length   = pc_n;
			out_word.suffix_length   = sc_n;
			out_word.length_overflow = ov_n;
			out_word.last_of_run     = 1'b1;
		end
	end

	assign out_wr = go && (emit_byte || emit_rec);
	assign mid_rd = go && !(emit_byte && entry.closes);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_BYTE;
			pc_q <= '0;
			sc_q <= '0;
			ov_q <= 1'b0;
		end else if (go) begin
			if (emit_byte && entry.closes) begin
				ph_q <= PH_RECORD;
				pc_q <= pc_n;
				sc_q <= sc_n;
				ov_q <= ov_n;
			end else if (entry.closes) begin
				ph_q <= PH_BYTE;
				pc_q <= '0;
				sc_q <= '0;
				ov_q <= 1'b0;
			end else begin
				pc_q <= pc_n;
				sc_q <= sc_n;
				ov_q <= ov_n;
			end
		end
	end

	a_record_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(ph_q == PH_RECORD) |-> (!mid_empty && entry.closes))
		else $error("record phase without a closing word");

	a_counts_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(go && emit_rec) |=> (pc_q == '0 && sc_q == '0 && !ov_q && ph_q == PH_BYTE))
		else $error("counts not cleared after length record");

	a_hold_split: assert property (@(posedge clk) disable iff (!arst_n)
		(go && emit_byte && entry.closes) |-> !mid_rd)
		else $error("closing word dropped before its length record");

endmodule

@@ rtl/prefix_share_string_encoder_core.sv @@
// Top level of the prefix-sharing (front coding) string encoder.
// Instantiates pse_front, pse_fifo and pse_back; depends on pse_pkg.
`timescale 1ns / 1ps

// The encoder takes one string byte per word and accepts a new word every cycle
// unless the front stage is held by a full queue. A word that ends a string with a
// suffix byte yields two results and holds the back part in a record phase for the
// second. Results pass the front stage register and both queues before the ports.
// The previous string lives in a MaxString-byte buffer that is read and rewritten
// at the same position in the acceptance cycle; no clearing pass follows reset. A
// four-word queue separates classification from counting, and a two-word result
// queue drives the result ports.
module prefix_share_string_encoder_core #(
	parameter int MaxString = pse_pkg::MAX_STRING
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  pse_pkg::pse_in_t  item,
	output logic              empty,
	input  logic              pop,
	output pse_pkg::pse_out_t result
);

	import pse_pkg::*;

	pse_mid_t mid_wword;
	pse_mid_t mid_rword;
	pse_out_t out_wword;
	logic     mid_wr;
	logic     mid_full;
	logic     mid_rd;
	logic     mid_empty;
	logic     out_wr;
	logic     out_full;

	pse_front #(
		.MaxString(MaxString)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.item     (item),
		.full     (full),
		.mid_wr   (mid_wr),
		.mid_word (mid_wword),
		.mid_full (mid_full)
	);

	pse_fifo #(
		.Width($bits(pse_mid_t)),
		.Depth(MID_DEPTH)
	) u_mid (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (mid_wr),
		.wdata  (mid_wword),
		.full   (mid_full),
		.rd     (mid_rd),
		.rdata  (mid_rword),
		.empty  (mid_empty)
	);

	pse_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.entry     (mid_rword),
		.mid_empty (mid_empty),
		.mid_rd    (mid_rd),
		.out_wr    (out_wr),
		.out_word  (out_wword),
		.out_full  (out_full)
	);

	pse_fifo #(
		.Width($bits(pse_out_t)),
		.Depth(OUT_DEPTH)
	) u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (out_wr),
		.wdata  (out_wword),
		.full   (out_full),
		.rd     (pop),
		.rdata  (result),
		.empty  (empty)
	);

endmodule
